>>> design/epw_pkg.sv
// ============================================================================
// epw_pkg: shared types and constants for the epispiral point warp
// Fixed-point formats, CORDIC angle table, register indexes and stage payloads.
// ============================================================================
package epw_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 20;

	localparam int ROT_W    = 34;
	localparam int Z_W      = 34;
	localparam int VEC_W    = 36;
	localparam int Q_BITS   = 33;
	localparam int DIV_SHIFT = 30;
	localparam int ROT_LAT  = CORDIC_STAGES + 1;
	localparam int DIV_LAT  = Q_BITS + 1;

	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0]             TURN_HALF   = 32'h8000_0000;
	localparam logic signed [31:0]      I32_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]      I32_MIN     = 32'sh8000_0000;

	localparam logic signed [31:0] PETAL_RST  = 32'(6 << FRAC_BITS);
	localparam logic signed [31:0] THICK_RST  = 32'sd0;
	localparam logic signed [31:0] HOLE_RST   = 32'(1 << FRAC_BITS);
	localparam logic signed [31:0] WEIGHT_RST = 32'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		REG_PETAL  = 2'd0,
		REG_THICK  = 2'd1,
		REG_HOLE   = 2'd2,
		REG_WEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic [30:0]        mn;
		logic               nneg;
	} vec_side_t;

	typedef struct packed {
		logic signed [31:0]      ax;
		logic signed [31:0]      ay;
		logic signed [ROT_W-1:0] ct;
		logic signed [ROT_W-1:0] st;
	} div_side_t;

	typedef struct packed {
		logic den_zero;
		logic too_big;
		logic neg;
		logic num_neg;
	} div_flags_t;

	// atan(2^-i) in binary angle units, one turn = 2^32
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			5'd31: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

>>> design/epw_if.sv
// ============================================================================
// epw_if: point channels
// Input point beat and warped output point beat, valid/ready handshake.
// ============================================================================
interface epw_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] src_x;
	logic signed [31:0] src_y;
	logic signed [31:0] accum_x;
	logic signed [31:0] accum_y;
	logic [15:0]        random_fraction;

	modport source (output valid, src_x, src_y, accum_x, accum_y, random_fraction,
		input ready);
	modport sink (input valid, src_x, src_y, accum_x, accum_y, random_fraction,
		output ready);
endinterface

interface epw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic               saturated;

	modport source (output valid, new_x, new_y, saturated, input ready);
	modport sink (input valid, new_x, new_y, saturated, output ready);
endinterface

>>> design/epw_rot.sv
// ============================================================================
// epw_rot: pipelined rotation CORDIC
// Cosine and sine of a binary angle in Q4.30, one stage per iteration.
// ============================================================================
module epw_rot (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              feed_valid,
	input  logic [31:0]                       angle,
	output logic                              res_valid,
	output logic signed [epw_pkg::ROT_W-1:0]  cos_val,
	output logic signed [epw_pkg::ROT_W-1:0]  sin_val
);
	localparam int N  = epw_pkg::CORDIC_STAGES;
	localparam int RW = epw_pkg::ROT_W;
	localparam int ZW = epw_pkg::Z_W;

	logic signed [RW-1:0] x_s [1:N];
	logic signed [RW-1:0] y_s [1:N];
	logic signed [ZW-1:0] z_s [1:N];
	logic                 flip_s [1:N];
	logic                 vld_s [1:N];

	// second and third quadrant turned by half a turn
	logic                 flip_in;
	logic [31:0]          ang_in;
	logic signed [ZW-1:0] z_in;

	assign flip_in = angle[31] ^ angle[30];
	assign ang_in  = {angle[31] ^ flip_in, angle[30:0]};
	assign z_in    = ZW'(signed'(ang_in));

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ANG = ZW'({1'b0, epw_pkg::atan_bam(5'(i))});
		logic signed [RW-1:0] xi, yi, dx, dy;
		logic signed [ZW-1:0] zi;
		logic                 fi, vi;

		if (i == 0) begin : g_head
			assign xi = epw_pkg::CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
			assign fi = flip_in;
			assign vi = feed_valid;
		end else begin : g_body
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign fi = flip_s[i];
			assign vi = vld_s[i];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[ZW-1]) begin
					x_s[i+1] <= xi - dx;
					y_s[i+1] <= yi + dy;
					z_s[i+1] <= zi - ANG;
				end else begin
					x_s[i+1] <= xi + dx;
					y_s[i+1] <= yi - dy;
					z_s[i+1] <= zi + ANG;
				end
				flip_s[i+1] <= fi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= flip_s[N] ? -x_s[N] : x_s[N];
			sin_val <= flip_s[N] ? -y_s[N] : y_s[N];
		end
	end

endmodule

>>> design/epw_div.sv
// ============================================================================
// epw_div: pipelined radius divider
// (|num| << 30) / |cos| as restoring division, one quotient bit per stage.
// ============================================================================
module epw_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              feed_valid,
	input  logic [30:0]                       num_mag,
	input  logic                              num_neg,
	input  logic signed [epw_pkg::ROT_W-1:0]  den,
	output logic                              res_valid,
	output logic [epw_pkg::Q_BITS-1:0]        quo,
	output epw_pkg::div_flags_t               flags
);
	localparam int Q  = epw_pkg::Q_BITS;
	localparam int RW = epw_pkg::ROT_W;

	logic [31:0]         mc_in;
	epw_pkg::div_flags_t fl_in;

	logic [31:0]         mc_s1;
	logic [30:0]         mn_s1;
	logic [31:0]         rem_s1;
	epw_pkg::div_flags_t fl_s1;
	logic                vld_s1;

	logic [31:0]         mc_sd  [1:Q];
	logic [30:0]         mn_sd  [1:Q];
	logic [31:0]         rem_sd [1:Q];
	logic [Q-1:0]        quo_sd [1:Q];
	epw_pkg::div_flags_t fl_sd  [1:Q];
	logic                vld_sd [1:Q];

	assign mc_in = den[RW-1] ? 32'(-den) : den[31:0];

	always_comb begin
		fl_in.den_zero = (mc_in == '0);
		fl_in.too_big  = ({4'b0, num_mag} >= {mc_in, 3'b0});
		fl_in.neg      = num_neg ^ den[RW-1];
		fl_in.num_neg  = num_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mc_s1  <= mc_in;
			mn_s1  <= num_mag;
			rem_s1 <= 32'(num_mag >> 3);
			fl_s1  <= fl_in;
		end
	end

	for (genvar k = 0; k < Q; k++) begin : g_bit
		localparam int B = Q - 1 - k;
		logic [31:0]         mci, remi;
		logic [30:0]         mni;
		logic [Q-1:0]        quoi;
		epw_pkg::div_flags_t fli;
		logic                vi, dbit, ge;
		logic [32:0]         trial;

		if (k == 0) begin : g_head
			assign mci  = mc_s1;
			assign mni  = mn_s1;
			assign remi = rem_s1;
			assign quoi = '0;
			assign fli  = fl_s1;
			assign vi   = vld_s1;
		end else begin : g_body
			assign mci  = mc_sd[k];
			assign mni  = mn_sd[k];
			assign remi = rem_sd[k];
			assign quoi = quo_sd[k];
			assign fli  = fl_sd[k];
			assign vi   = vld_sd[k];
		end

		if (B >= epw_pkg::DIV_SHIFT) begin : g_num
			assign dbit = mni[B-epw_pkg::DIV_SHIFT];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign trial = {remi, dbit};
		assign ge    = (trial >= {1'b0, mci});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k+1] <= ge ? 32'(trial - {1'b0, mci}) : trial[31:0];
				quo_sd[k+1] <= {quoi[Q-2:0], ge};
				mc_sd[k+1]  <= mci;
				mn_sd[k+1]  <= mni;
				fl_sd[k+1]  <= fli;
			end
		end
	end

	assign res_valid = vld_sd[Q];
	assign quo       = quo_sd[Q];
	assign flags     = fl_sd[Q];

endmodule

>>> design/epispiral_point_warp.sv
// ============================================================================
// epispiral_point_warp: epispiral flame variation on Q16.16 points
// Angle, spiral radius and weighted offset in a fully pipelined datapath.
// ============================================================================
// One point is accepted every clock unless the output stalls. Stages: 3
// normalize, 20 vectoring CORDIC, one frequency multiply, 21 rotation CORDIC,
// 34 divider and 6 for radius, weight and output arithmetic. A one-beat skid
// register at the output lets a stalled consumer hold the pipeline without
// losing a beat. The user must write registers through the APB port only
// while no point is in flight; the block itself does not enforce this.
module epispiral_point_warp (
	input  logic             clk,
	input  logic             arst_n,
	epw_in_if.sink           sample,
	epw_out_if.source        result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int N  = epw_pkg::CORDIC_STAGES;
	localparam int VW = epw_pkg::VEC_W;
	localparam int RW = epw_pkg::ROT_W;
	localparam int FB = epw_pkg::FRAC_BITS;

	// ---------------- registers ----------------
	logic signed [31:0] petal_q, thick_q, hole_q, weight_q;
	logic               cfg_wr;
	epw_pkg::reg_idx_t  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = epw_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			petal_q  <= epw_pkg::PETAL_RST;
			thick_q  <= epw_pkg::THICK_RST;
			hole_q   <= epw_pkg::HOLE_RST;
			weight_q <= epw_pkg::WEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				epw_pkg::REG_PETAL:  petal_q  <= pwdata;
				epw_pkg::REG_THICK:  thick_q  <= pwdata;
				epw_pkg::REG_HOLE:   hole_q   <= pwdata;
				epw_pkg::REG_WEIGHT: weight_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			epw_pkg::REG_PETAL:  prdata = petal_q;
			epw_pkg::REG_THICK:  prdata = thick_q;
			epw_pkg::REG_HOLE:   prdata = hole_q;
			epw_pkg::REG_WEIGHT: prdata = weight_q;
		endcase
	end

	// ---------------- stall ----------------
	logic en, skid_q;

	assign en           = !skid_q;
	assign sample.ready = en;

	// ---------------- s1: half turn, thickness product ----------------
	logic signed [32:0] sx_ext, sy_ext, x_pre, y_pre;
	logic [31:0]        my_pre, thick_abs;
	logic [47:0]        rt_prod;
	epw_pkg::vec_side_t side_pre;

	assign sx_ext    = 33'(sample.src_x);
	assign sy_ext    = 33'(sample.src_y);
	assign x_pre     = sample.src_x[31] ? -sx_ext : sx_ext;
	assign y_pre     = sample.src_x[31] ? -sy_ext : sy_ext;
	assign my_pre    = y_pre[32] ? 32'(-y_pre) : y_pre[31:0];
	assign thick_abs = thick_q[31] ? 32'(-33'(thick_q)) : 32'(thick_q);
	assign rt_prod   = 48'(sample.random_fraction) * 48'(thick_abs);

	always_comb begin
		side_pre.ax   = sample.accum_x;
		side_pre.ay   = sample.accum_y;
		side_pre.mn   = rt_prod[46:16];
		side_pre.nneg = thick_q[31] && (rt_prod[46:16] != '0);
	end

	logic signed [32:0] x_s1, y_s1;
	logic [31:0]        z_s1, mor_s1;
	logic               zero_s1, vld_s1;
	epw_pkg::vec_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_pre;
			y_s1    <= y_pre;
			z_s1    <= sample.src_x[31] ? epw_pkg::TURN_HALF : '0;
			zero_s1 <= (sample.src_x == '0) && (sample.src_y == '0);
			mor_s1  <= x_pre[31:0] | my_pre;
			side_s1 <= side_pre;
		end
	end

	// ---------------- s2: normalize shift count ----------------
	logic [4:0] sh_pre;

	always_comb begin
		sh_pre = '0;
		for (int k = 0; k < 32; k++) begin
			if (mor_s1[k]) begin
				sh_pre = (k >= 30) ? 5'd0 : 5'(30 - k);
			end
		end
	end

	logic signed [32:0] x_s2, y_s2;
	logic [31:0]        z_s2;
	logic [4:0]         sh_s2;
	logic               zero_s2, vld_s2;
	epw_pkg::vec_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			sh_s2   <= sh_pre;
			zero_s2 <= zero_s1;
			side_s2 <= side_s1;
		end
	end

	// ---------------- s3: normalize ----------------
	logic signed [VW-1:0] vx_s3, vy_s3;
	logic [31:0]          vz_s3;
	logic                 zero_s3, vld_s3;
	epw_pkg::vec_side_t   side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s3   <= VW'(x_s2) <<< sh_s2;
			vy_s3   <= VW'(y_s2) <<< sh_s2;
			vz_s3   <= z_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------- vectoring CORDIC ----------------
	logic signed [VW-1:0] vx_sc [1:N];
	logic signed [VW-1:0] vy_sc [1:N];
	logic [31:0]          vz_sc [1:N];
	logic                 vzero_sc [1:N];
	logic                 vvld_sc [1:N];
	epw_pkg::vec_side_t   vside_sc [1:N];

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic [31:0] ANG = epw_pkg::atan_bam(5'(i));
		logic signed [VW-1:0] xi, yi, dx, dy;
		logic [31:0]          zi;
		logic                 zri, vi;
		epw_pkg::vec_side_t   si;

		if (i == 0) begin : g_head
			assign xi  = vx_s3;
			assign yi  = vy_s3;
			assign zi  = vz_s3;
			assign zri = zero_s3;
			assign vi  = vld_s3;
			assign si  = side_s3;
		end else begin : g_body
			assign xi  = vx_sc[i];
			assign yi  = vy_sc[i];
			assign zi  = vz_sc[i];
			assign zri = vzero_sc[i];
			assign vi  = vvld_sc[i];
			assign si  = vside_sc[i];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vvld_sc[i+1] <= 1'b0;
			end else if (en) begin
				vvld_sc[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[VW-1] && (yi != '0)) begin
					vx_sc[i+1] <= xi + dx;
					vy_sc[i+1] <= yi - dy;
					vz_sc[i+1] <= zi + ANG;
				end else begin
					vx_sc[i+1] <= xi - dx;
					vy_sc[i+1] <= yi + dy;
					vz_sc[i+1] <= zi - ANG;
				end
				vzero_sc[i+1] <= zri;
				vside_sc[i+1] <= si;
			end
		end
	end

	// ---------------- s4: n * theta ----------------
	logic [31:0]        theta;
	logic signed [63:0] nprod;

	assign theta = vzero_sc[N] ? '0 : vz_sc[N];
	assign nprod = 64'(petal_q) * 64'(signed'(theta));

	logic [31:0]        nth_s4, th_s4;
	logic               vld_s4;
	epw_pkg::vec_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vvld_sc[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nth_s4  <= nprod[FB+31:FB];
			th_s4   <= theta;
			side_s4 <= vside_sc[N];
		end
	end

	// ---------------- cos/sin ----------------
	logic signed [RW-1:0] cn, ct, st;
	logic                 rot_vld;

	epw_rot u_rot_n (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.feed_valid (vld_s4),
		.angle      (nth_s4),
		.res_valid  (rot_vld),
		.cos_val    (cn),
		.sin_val    ()
	);

	epw_rot u_rot_t (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.feed_valid (vld_s4),
		.angle      (th_s4),
		.res_valid  (),
		.cos_val    (ct),
		.sin_val    (st)
	);

	epw_pkg::vec_side_t side_dly [epw_pkg::ROT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly[0] <= side_s4;
			for (int k = 1; k < epw_pkg::ROT_LAT; k++) begin
				side_dly[k] <= side_dly[k-1];
			end
		end
	end

	// ---------------- divide ----------------
	logic                     div_vld;
	logic [epw_pkg::Q_BITS-1:0] quo;
	epw_pkg::div_flags_t      dflags;
	epw_pkg::div_side_t       dside_in;

	epw_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.feed_valid (rot_vld),
		.num_mag    (side_dly[epw_pkg::ROT_LAT-1].mn),
		.num_neg    (side_dly[epw_pkg::ROT_LAT-1].nneg),
		.den        (cn),
		.res_valid  (div_vld),
		.quo        (quo),
		.flags      (dflags)
	);

	always_comb begin
		dside_in.ax = side_dly[epw_pkg::ROT_LAT-1].ax;
		dside_in.ay = side_dly[epw_pkg::ROT_LAT-1].ay;
		dside_in.ct = ct;
		dside_in.st = st;
	end

	epw_pkg::div_side_t dside_dly [epw_pkg::DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dside_dly[0] <= dside_in;
			for (int k = 1; k < epw_pkg::DIV_LAT; k++) begin
				dside_dly[k] <= dside_dly[k-1];
			end
		end
	end

	// ---------------- s5: radius t ----------------
	logic signed [34:0] sq;
	logic signed [35:0] tdiff;
	logic signed [31:0] t_pre;
	logic               tflag;

	assign sq    = dflags.neg ? -35'({2'b0, quo}) : 35'({2'b0, quo});
	assign tdiff = 36'(sq) - 36'(hole_q);

	always_comb begin
		tflag = 1'b0;
		t_pre = tdiff[31:0];
		priority if (dflags.den_zero) begin
			tflag = 1'b1;
			t_pre = dflags.num_neg ? epw_pkg::I32_MIN : epw_pkg::I32_MAX;
		end else if (dflags.too_big) begin
			tflag = 1'b1;
			t_pre = dflags.neg ? epw_pkg::I32_MIN : epw_pkg::I32_MAX;
		end else if (tdiff > 36'(epw_pkg::I32_MAX)) begin
			tflag = 1'b1;
			t_pre = epw_pkg::I32_MAX;
		end else if (tdiff < 36'(epw_pkg::I32_MIN)) begin
			tflag = 1'b1;
			t_pre = epw_pkg::I32_MIN;
		end else begin
			t_pre = tdiff[31:0];
		end
	end

	logic signed [31:0] t_s5;
	logic               flag_s5, vld_s5;
	epw_pkg::div_side_t ds_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5    <= t_pre;
			flag_s5 <= tflag;
			ds_s5   <= dside_dly[epw_pkg::DIV_LAT-1];
		end
	end

	// ---------------- s6: weight * t ----------------
	logic signed [63:0] p_s6;
	logic               flag_s6, vld_s6;
	epw_pkg::div_side_t ds_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6    <= 64'(weight_q) * 64'(t_s5);
			flag_s6 <= flag_s5;
			ds_s6   <= ds_s5;
		end
	end

	// ---------------- s7: magnitudes ----------------
	logic [62:0]        mp_s7;
	logic [31:0]        mcx_s7, mcy_s7;
	logic               negx_s7, negy_s7, flag_s7, vld_s7;
	logic signed [31:0] ax_s7, ay_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s7   <= p_s6[63] ? 63'(-p_s6) : p_s6[62:0];
			mcx_s7  <= ds_s6.ct[RW-1] ? 32'(-ds_s6.ct) : ds_s6.ct[31:0];
			mcy_s7  <= ds_s6.st[RW-1] ? 32'(-ds_s6.st) : ds_s6.st[31:0];
			negx_s7 <= p_s6[63] ^ ds_s6.ct[RW-1];
			negy_s7 <= p_s6[63] ^ ds_s6.st[RW-1];
			flag_s7 <= flag_s6;
			ax_s7   <= ds_s6.ax;
			ay_s7   <= ds_s6.ay;
		end
	end

	// ---------------- s8: partial products ----------------
	logic [63:0]        lmx_s8, lmy_s8;
	logic [62:0]        hix_s8, hiy_s8;
	logic               negx_s8, negy_s8, flag_s8, vld_s8;
	logic signed [31:0] ax_s8, ay_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lmx_s8  <= 64'(mp_s7[31:0]) * 64'(mcx_s7);
			lmy_s8  <= 64'(mp_s7[31:0]) * 64'(mcy_s7);
			hix_s8  <= 63'(mp_s7[62:32]) * 63'(mcx_s7);
			hiy_s8  <= 63'(mp_s7[62:32]) * 63'(mcy_s7);
			negx_s8 <= negx_s7;
			negy_s8 <= negy_s7;
			flag_s8 <= flag_s7;
			ax_s8   <= ax_s7;
			ay_s8   <= ay_s7;
		end
	end

	// ---------------- s9: combine and scale ----------------
	logic [63:0] midx, midy, rmx, rmy;

	assign midx = 64'(hix_s8) + (lmx_s8 >> 32);
	assign midy = 64'(hiy_s8) + (lmy_s8 >> 32);
	assign rmx  = midx >> (FB - 2);
	assign rmy  = midy >> (FB - 2);

	logic signed [63:0] rx_s9, ry_s9;
	logic               flag_s9, vld_s9;
	logic signed [31:0] ax_s9, ay_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s9   <= negx_s8 ? -signed'(rmx) : signed'(rmx);
			ry_s9   <= negy_s8 ? -signed'(rmy) : signed'(rmy);
			flag_s9 <= flag_s8;
			ax_s9   <= ax_s8;
			ay_s9   <= ay_s8;
		end
	end

	// ---------------- s10: accumulate and clamp ----------------
	logic signed [64:0] sumx, sumy;
	logic signed [31:0] nx_pre, ny_pre;
	logic               fx, fy;

	assign sumx = 65'(ax_s9) + 65'(rx_s9);
	assign sumy = 65'(ay_s9) + 65'(ry_s9);

	always_comb begin
		fx     = 1'b1;
		nx_pre = epw_pkg::I32_MAX;
		priority if (sumx > 65'(epw_pkg::I32_MAX)) begin
			nx_pre = epw_pkg::I32_MAX;
		end else if (sumx < 65'(epw_pkg::I32_MIN)) begin
			nx_pre = epw_pkg::I32_MIN;
		end else begin
			fx     = 1'b0;
			nx_pre = sumx[31:0];
		end
	end

	always_comb begin
		fy     = 1'b1;
		ny_pre = epw_pkg::I32_MAX;
		priority if (sumy > 65'(epw_pkg::I32_MAX)) begin
			ny_pre = epw_pkg::I32_MAX;
		end else if (sumy < 65'(epw_pkg::I32_MIN)) begin
			ny_pre = epw_pkg::I32_MIN;
		end else begin
			fy     = 1'b0;
			ny_pre = sumy[31:0];
		end
	end

	logic signed [31:0] nx_s10, ny_s10;
	logic               sat_s10, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s10  <= nx_pre;
			ny_s10  <= ny_pre;
			sat_s10 <= flag_s9 || fx || fy;
		end
	end

	// ---------------- output skid ----------------
	logic signed [31:0] skid_x_q, skid_y_q;
	logic               skid_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			skid_q <= !result.ready;
		end else begin
			skid_q <= vld_s10 && !result.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_x_q   <= nx_s10;
			skid_y_q   <= ny_s10;
			skid_sat_q <= sat_s10;
		end
	end

	assign result.valid     = skid_q || vld_s10;
	assign result.new_x     = skid_q ? skid_x_q : nx_s10;
	assign result.new_y     = skid_q ? skid_y_q : ny_s10;
	assign result.saturated = skid_q ? skid_sat_q : sat_s10;

endmodule

>>> design/epw_checker.sv
// ============================================================================
// epw_checker: port-level checks for the epispiral point warp
// Output handshake, stall and reset behavior seen at the top-level ports.
// ============================================================================
module epw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] new_x,
	input logic [31:0] new_y,
	input logic        saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_x) && $stable(new_y) && $stable(saturated))
		else $error("output beat changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && in_ready)
		else $error("pipeline not empty after reset");

endmodule

bind epispiral_point_warp epw_checker u_epw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.new_x     (result.new_x),
	.new_y     (result.new_y),
	.saturated (result.saturated)
);
